### rtl/assert_macros.svh
// Assertion macros used by the checker file srm_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/srm_pkg.sv
// Package for the segment range merger: beat types, constants and states.
// No dependencies.
`default_nettype none
package srm_pkg;
	localparam int MaxRanges = 16;
	localparam int IdxW = $clog2(MaxRanges);
	localparam int CntW = $clog2(MaxRanges + 1);
	localparam logic [24:0] StreamCapacity = 25'd16777216;
	localparam logic [24:0] DefaultLimit = 25'd8388608;

	typedef struct packed {
		logic [23:0] seg_offset;
		logic [15:0] seg_length;
		logic        fin_seen;
	} srm_in_t;

	typedef struct packed {
		logic [4:0]  range_count;
		logic [24:0] stream_length;
		logic        contiguous;
		logic        complete;
		logic        over_limit;
		logic        dropped;
	} srm_out_t;

	// One table entry: start and end of a held range.
	typedef struct packed {
		logic [23:0] rstart;
		logic [24:0] rend;
	} srm_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE,
		ST_DONE
	} srm_state_t;
endpackage
`default_nettype wire

### rtl/srm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module srm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/segment_range_merger_core.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------
// in        | in_valid / in_ready    | srm_in_t  (offset, length, fin)
// out       | out_valid / out_ready  | srm_out_t (count, length, flags)
// cfg       | cfg_we                 | cfg_data: max_stream_bytes
// From accept to result, one read pass over the table memory finds the merge window
// and stops at the first range past it, then the entries above the window move up
// or down one per cycle on the single read port.
// The result register holds a finished beat while the output stalls; a new segment
// is taken only after that beat has left.
// Reset clears the count and the stream length and loads the default limit; the
// table memory needs no clearing because only entries below the count are read.
// Top level of the segment range merger; uses srm_pkg and srm_ram.
`default_nettype none
module segment_range_merger_core
	import srm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire srm_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output srm_out_t      out_data,
	input  wire logic     cfg_we,
	input  wire logic [24:0] cfg_data
);
	srm_state_t state_q, state_d;
	logic [CntW-1:0] total_q, total_d;
	logic [24:0] hw_q, hw_d, limit_q;
	logic [23:0] lo_q, lo_d;
	logic [24:0] hi_q, hi_d;
	logic fin_q, fin_d, drop_q, drop_d;
	// Scan pointers: read address issued and entry under test.
	logic [CntW-1:0] ra_q, ra_d, pos_q, pos_d;
	logic [CntW-1:0] first_q, first_d, past_q, past_d;
	logic phase_q, phase_d;
	logic out_valid_q, out_valid_d;
	srm_out_t out_q, out_d;
	// Move pass: source index and step direction.
	logic [CntW-1:0] src_q, src_d, dst_q, dst_d, src_end_q, src_end_d;
	logic up_q, up_d;

	logic we;
	logic [IdxW-1:0] waddr, raddr;
	srm_entry_t wdata, rdata;

	srm_ram #(.Width($bits(srm_entry_t)), .Depth(MaxRanges)) u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [24:0] seg_end;
	assign seg_end = {1'b0, lo_q} + {9'd0, hi_q[15:0]};

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= DefaultLimit;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			hw_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			hw_q <= hw_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		lo_q <= lo_d; hi_q <= hi_d; fin_q <= fin_d; drop_q <= drop_d;
		ra_q <= ra_d; pos_q <= pos_d; first_q <= first_d; past_q <= past_d;
		phase_q <= phase_d; out_q <= out_d;
		src_q <= src_d; dst_q <= dst_d; src_end_q <= src_end_d; up_q <= up_d;
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Sequencer. During scan hi_q first holds the raw length, then the end.
	always_comb begin
		state_d = state_q; total_d = total_q; hw_d = hw_q;
		lo_d = lo_q; hi_d = hi_q; fin_d = fin_q; drop_d = drop_q;
		ra_d = ra_q; pos_d = pos_q; first_d = first_q; past_d = past_q;
		phase_d = phase_q;
		out_valid_d = out_valid_q && !out_ready; out_d = out_q;
		src_d = src_q; dst_d = dst_q; src_end_d = src_end_q; up_d = up_q;
		we = 1'b0; waddr = dst_q[IdxW-1:0]; wdata = rdata;
		raddr = ra_q[IdxW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					lo_d = in_data.seg_offset;
					hi_d = {9'd0, in_data.seg_length};
					fin_d = in_data.fin_seen;
					state_d = ST_SCAN;
					phase_d = 1'b1;
					ra_d = '0; pos_d = '0;
				end
			end
			ST_SCAN: begin
				if (phase_q) begin
					// First cycle: form the segment end.
					hi_d = seg_end;
					phase_d = 1'b0;
					drop_d = seg_end > StreamCapacity;
					first_d = '0;
					if (total_q != '0) begin
						ra_d = ra_q + 1'b1;
					end else begin
						past_d = '0;
						state_d = ST_DECIDE;
					end
				end else begin
					// Each cycle tests the entry read the cycle before.
					if (rdata.rend < hi_q && rdata.rend < {1'b0, lo_q}) begin
						first_d = pos_q + 1'b1;
					end
					if (rdata.rend < {1'b0, lo_q} || {1'b0, rdata.rstart} <= hi_q) begin
						pos_d = pos_q + 1'b1;
						if (!(rdata.rend < {1'b0, lo_q})) begin
							// Merge candidate: widen the window.
							if (pos_q == first_q && rdata.rstart < lo_q) begin
								lo_d = rdata.rstart;
							end
							if (rdata.rend > hi_q) begin
								hi_d = rdata.rend;
							end
						end else begin
							first_d = pos_q + 1'b1;
						end
						if (pos_q + 1'b1 == total_q) begin
							past_d = pos_q + 1'b1;
							state_d = ST_DECIDE;
						end else begin
							ra_d = ra_q + 1'b1;
						end
					end else begin
						past_d = pos_q;
						state_d = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				if (!drop_q && past_q == first_q && total_q == CntW'(MaxRanges)) begin
					drop_d = 1'b1;
				end
				if (drop_q || (past_q == first_q && total_q == CntW'(MaxRanges))) begin
					state_d = ST_DONE;
				end else if (past_q == first_q) begin
					// Insert: shift entries up from the top.
					up_d = 1'b1;
					src_d = total_q; src_end_d = first_q;
					ra_d = total_q - 1'b1;
					total_d = total_q + 1'b1;
					if (hi_q > hw_q) hw_d = hi_q;
					state_d = ST_MOVE; phase_d = 1'b1;
				end else begin
					// Merge: close the gap from past down to first+1.
					up_d = 1'b0;
					src_d = past_q; src_end_d = total_q;
					dst_d = first_q + 1'b1;
					ra_d = past_q;
					total_d = total_q - (past_q - first_q - 1'b1);
					if (hi_q > hw_q) hw_d = hi_q;
					we = 1'b1; waddr = first_q[IdxW-1:0];
					wdata.rstart = lo_q; wdata.rend = hi_q;
					state_d = ST_MOVE; phase_d = 1'b1;
				end
			end
			ST_MOVE: begin
				if (up_q) begin
					// src_q is the slot to fill from src_q-1; reads run one entry ahead.
					if (phase_q) begin
						phase_d = 1'b0;
						if (src_q == src_end_q) begin
							we = 1'b1; waddr = first_q[IdxW-1:0];
							wdata.rstart = lo_q; wdata.rend = hi_q;
							state_d = ST_DONE;
						end else begin
							ra_d = src_q - 2'd2;
						end
					end else begin
						we = 1'b1; waddr = src_q[IdxW-1:0];
						src_d = src_q - 1'b1;
						if (src_q - 1'b1 == src_end_q) begin
							state_d = ST_MOVE; phase_d = 1'b1;
						end else begin
							ra_d = src_q - 2'd3; phase_d = 1'b0;
						end
					end
				end else begin
					if (phase_q) begin
						phase_d = 1'b0;
						if (src_q == src_end_q) state_d = ST_DONE;
						else ra_d = src_q + 1'b1;
					end else begin
						we = 1'b1; waddr = dst_q[IdxW-1:0];
						dst_d = dst_q + 1'b1;
						src_d = src_q + 1'b1;
						if (src_q + 1'b1 == src_end_q) state_d = ST_DONE;
						else ra_d = src_q + 2'd2;
					end
				end
			end
			ST_DONE: begin
				out_valid_d = 1'b1;
				out_d.range_count = 5'(total_q);
				out_d.stream_length = hw_q;
				out_d.contiguous = total_q <= CntW'(1);
				out_d.complete = fin_q && (total_q <= CntW'(1));
				out_d.over_limit = hw_q > limit_q;
				out_d.dropped = drop_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/srm_checker.sv
// Port-level checker for the segment range merger, bound to the top level.
// Uses srm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module srm_port_checker
	import srm_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire srm_out_t out_data
);
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "result beat changed while stalled")
	`CHK_IMPL(a_one_at_a_time, clk, arst_n, out_valid, !in_ready,
		"input taken while a result waits")
	`CHK_IMPL(a_count_range, clk, arst_n, out_valid,
		out_data.range_count <= 5'(MaxRanges), "range count above table size")
	`CHK_IMPL(a_contig, clk, arst_n, out_valid,
		out_data.contiguous == (out_data.range_count <= 5'd1),
		"contiguous flag disagrees with count")
	`CHK_NEXT(a_no_early, clk, arst_n, in_valid && in_ready, !out_valid,
		"result in the cycle after accept")
endmodule

bind segment_range_merger_core srm_port_checker u_srm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
